/* rtl/obea_pkg.sv */
// Shared constants and types for the ordered bucket entry allocator.
// Depends on nothing; the core refers to it by scoped names.
package obea_pkg;

	// Store geometry.
	localparam int ENTRY_COUNT  = 64;
	localparam int BUCKET_COUNT = 32;
	localparam int SLOT_W       = $clog2(ENTRY_COUNT);
	localparam int BKT_W        = $clog2(BUCKET_COUNT);
	localparam int CNT_W        = SLOT_W + 1;

	// Pattern written into hidden image positions.
	localparam logic [15:0] HIDDEN_WORD = 16'h0200;

	// Command codes of the input word.
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// Result kinds.
	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_ENTRY = 2'd1;
	localparam logic [1:0] KIND_FILL  = 2'd2;

	typedef logic [15:0] half_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [BKT_W-1:0] bkt_t;
	typedef logic [CNT_W-1:0] cnt_t;

endpackage

/* rtl/ordered_bucket_entry_allocator_core.sv */
// Ordered bucket entry allocator: collects entries into order buckets and drains
// them as one ordered image. Depends on obea_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one word at a time: an allocation
//   (command 0) or a flush (command 1). in_ready is high only while the
//   sequencer is idle.
//   Output channel (out_valid/out_ready) gives one word per allocation, and
//   one word per stored entry plus one per hidden fill position for a flush;
//   last marks the final word of each input. A flush with nothing to emit
//   gives no word at all.
//   An allocation is accepted, then does one read-modify-write of the bucket
//   head/tail and the store. In a flush every entry costs a registered read
//   of the entry store followed by the link chase, and every bucket, empty
//   or not, is visited by the bucket scan.
//   A stalled receiver holds the output register; the sequencer waits in its
//   allocation, emit or fill state until the word is taken.
//   Reset empties all buckets, clears the fill count and the paused boundary.
//   The store contents need no clearing: a slot is only read after it is
//   written.
module ordered_bucket_entry_allocator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [7:0]  order,
	input  logic [15:0] attr_word0,
	input  logic [15:0] attr_word1,
	input  logic [15:0] attr_word2,
	input  logic        hide_fill_mode,
	input  logic        pause_mode,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic        full_res,
	output logic [5:0]  slot,
	output logic [5:0]  position,
	output logic [5:0]  rank,
	output logic [15:0] out_word0,
	output logic [15:0] out_word1,
	output logic [15:0] out_word2,
	output logic        last
);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ALLOC = 3'd1;
	localparam logic [2:0] ST_BKT   = 3'd2;
	localparam logic [2:0] ST_RD    = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;
	localparam logic [2:0] ST_FILL  = 3'd5;

	localparam int ENTRIES = obea_pkg::ENTRY_COUNT;
	localparam int BUCKETS = obea_pkg::BUCKET_COUNT;

	// Entry store and link memory, single write and single registered read.
	obea_pkg::half_t store_w0 [ENTRIES];
	obea_pkg::half_t store_w1 [ENTRIES];
	obea_pkg::half_t store_w2 [ENTRIES];
	obea_pkg::slot_t link_mem [ENTRIES];

	// Bucket heads with valid bits, and bucket tails.
	obea_pkg::slot_t head_q [BUCKETS];
	obea_pkg::slot_t tail_q [BUCKETS];
	logic [BUCKETS-1:0] head_v_q;

	logic [2:0]       st_q;
	obea_pkg::cnt_t   used_q;
	obea_pkg::cnt_t   pb_q;
	obea_pkg::cnt_t   cnt_q;
	obea_pkg::cnt_t   base_q;
	obea_pkg::cnt_t   rank_q;
	obea_pkg::cnt_t   fpos_q;
	obea_pkg::cnt_t   fend_q;
	obea_pkg::bkt_t   bkt_q;
	obea_pkg::slot_t  idx_q;
	obea_pkg::bkt_t   ord_q;
	obea_pkg::half_t  w0_q, w1_q, w2_q;
	obea_pkg::half_t  rd_w0_q, rd_w1_q, rd_w2_q;
	obea_pkg::slot_t  rd_link_q;

	logic             out_valid_q;
	logic [1:0]       kind_q;
	logic             full_q;
	logic [5:0]       slot_q, pos_q, rank_out_q;
	obea_pkg::half_t  ow0_q, ow1_q, ow2_q;
	logic             last_q;

	logic             out_free;
	logic             in_take;
	logic             full_now;
	logic             alloc_go, alloc_ok, emit_go, fill_go, fill_done;
	logic             bkt_last, list_end, load_out;
	obea_pkg::slot_t  new_slot;
	obea_pkg::cnt_t   next_rank;
	obea_pkg::bkt_t   ord_clamp;
	obea_pkg::cnt_t   acc_base, acc_fstart, acc_fend;
	logic             acc_pause;

	logic [1:0]       nx_kind;
	logic             nx_full;
	logic [5:0]       nx_slot, nx_pos, nx_rank;
	obea_pkg::half_t  nx_w0, nx_w1, nx_w2;
	logic             nx_last;

	// Handshake and step conditions.
	assign in_ready  = (st_q == ST_IDLE);
	assign in_take   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign full_now  = (used_q >= obea_pkg::cnt_t'(ENTRIES));
	assign new_slot  = used_q[obea_pkg::SLOT_W-1:0];
	assign alloc_go  = (st_q == ST_ALLOC) && out_free;
	assign alloc_ok  = alloc_go && !full_now;
	assign emit_go   = (st_q == ST_EMIT) && out_free;
	assign fill_done = (st_q == ST_FILL) && (fpos_q == fend_q);
	assign fill_go   = (st_q == ST_FILL) && (fpos_q != fend_q) && out_free;
	assign load_out  = alloc_go || emit_go || fill_go;
	assign bkt_last  = (bkt_q == obea_pkg::bkt_t'(BUCKETS - 1));
	assign list_end  = (idx_q == tail_q[bkt_q]);
	assign next_rank = rank_q + obea_pkg::cnt_t'(1);

	// Order clamp to the last bucket.
	assign ord_clamp = (order > 8'(BUCKETS - 1)) ? obea_pkg::bkt_t'(BUCKETS - 1)
	                                             : obea_pkg::bkt_t'(order);

	// Image layout of a flush, worked out when the flush is accepted.
	always_comb begin
		acc_pause  = !hide_fill_mode && pause_mode;
		acc_base   = acc_pause ? (obea_pkg::cnt_t'(ENTRIES) - used_q) : '0;
		acc_fstart = '0;
		acc_fend   = '0;
		if (hide_fill_mode) begin
			acc_fstart = used_q;
			acc_fend   = (pb_q > used_q) ? pb_q : used_q;
		end else if (acc_pause) begin
			acc_fend   = acc_base;
		end
	end

	// Next output word.
	always_comb begin
		nx_kind = obea_pkg::KIND_ALLOC;
		nx_full = 1'b0;
		nx_slot = '0;
		nx_pos  = '0;
		nx_rank = '0;
		nx_w0   = '0;
		nx_w1   = '0;
		nx_w2   = '0;
		nx_last = 1'b1;
		case (st_q)
			ST_ALLOC: begin
				nx_full = full_now;
				if (!full_now) begin
					nx_slot = 6'(new_slot);
					nx_w0   = w0_q;
					nx_w1   = w1_q;
					nx_w2   = w2_q;
				end
			end
			ST_EMIT: begin
				nx_kind = obea_pkg::KIND_ENTRY;
				nx_slot = 6'(idx_q);
				nx_pos  = 6'(base_q + rank_q);
				nx_rank = 6'(rank_q);
				nx_w0   = rd_w0_q;
				nx_w1   = rd_w1_q;
				nx_w2   = rd_w2_q;
				nx_last = (next_rank == cnt_q) && (fpos_q == fend_q);
			end
			ST_FILL: begin
				nx_kind = obea_pkg::KIND_FILL;
				nx_pos  = 6'(fpos_q);
				nx_w0   = obea_pkg::HIDDEN_WORD;
				nx_w1   = obea_pkg::HIDDEN_WORD;
				nx_w2   = obea_pkg::HIDDEN_WORD;
				nx_last = (fpos_q + obea_pkg::cnt_t'(1) == fend_q);
			end
			default: begin
				nx_last = 1'b1;
			end
		endcase
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			used_q      <= '0;
			pb_q        <= '0;
			head_v_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (in_take) begin
						if (command == obea_pkg::CMD_ALLOC) begin
							st_q <= ST_ALLOC;
						end else begin
							st_q <= ST_BKT;
							if (!hide_fill_mode) begin
								pb_q <= acc_base;
							end
						end
					end
				end
				ST_ALLOC: begin
					if (alloc_go) begin
						st_q <= ST_IDLE;
					end
					if (alloc_ok) begin
						used_q          <= used_q + obea_pkg::cnt_t'(1);
						head_v_q[ord_q] <= 1'b1;
					end
				end
				ST_BKT: begin
					if (head_v_q[bkt_q]) begin
						st_q <= ST_RD;
					end else if (bkt_last) begin
						st_q <= ST_FILL;
					end
				end
				ST_RD: begin
					st_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						if (!list_end) begin
							st_q <= ST_RD;
						end else if (bkt_last) begin
							st_q <= ST_FILL;
						end else begin
							st_q <= ST_BKT;
						end
					end
				end
				ST_FILL: begin
					if (fill_done) begin
						st_q     <= ST_IDLE;
						used_q   <= '0;
						head_v_q <= '0;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Walk registers, input capture and output word.
	always_ff @(posedge clk) begin
		if (in_take) begin
			ord_q  <= ord_clamp;
			w0_q   <= attr_word0;
			w1_q   <= attr_word1;
			w2_q   <= attr_word2;
			cnt_q  <= used_q;
			base_q <= acc_base;
			fpos_q <= acc_fstart;
			fend_q <= acc_fend;
			rank_q <= '0;
			bkt_q  <= '0;
		end
		if (st_q == ST_BKT) begin
			if (head_v_q[bkt_q]) begin
				idx_q <= head_q[bkt_q];
			end else if (!bkt_last) begin
				bkt_q <= bkt_q + obea_pkg::bkt_t'(1);
			end
		end
		if (emit_go) begin
			rank_q <= next_rank;
			if (!list_end) begin
				idx_q <= rd_link_q;
			end else if (!bkt_last) begin
				bkt_q <= bkt_q + obea_pkg::bkt_t'(1);
			end
		end
		if (fill_go) begin
			fpos_q <= fpos_q + obea_pkg::cnt_t'(1);
		end
		if (load_out) begin
			kind_q     <= nx_kind;
			full_q     <= nx_full;
			slot_q     <= nx_slot;
			pos_q      <= nx_pos;
			rank_out_q <= nx_rank;
			ow0_q      <= nx_w0;
			ow1_q      <= nx_w1;
			ow2_q      <= nx_w2;
			last_q     <= nx_last;
		end
	end

	// Bucket head and tail update on a successful allocation.
	always_ff @(posedge clk) begin
		if (alloc_ok) begin
			tail_q[ord_q] <= new_slot;
			if (!head_v_q[ord_q]) begin
				head_q[ord_q] <= new_slot;
			end
		end
	end

	// Entry store and links: written on allocation, read during the walk.
	always_ff @(posedge clk) begin
		if (alloc_ok) begin
			store_w0[new_slot] <= w0_q;
			store_w1[new_slot] <= w1_q;
			store_w2[new_slot] <= w2_q;
			if (head_v_q[ord_q]) begin
				link_mem[tail_q[ord_q]] <= new_slot;
			end
		end
		if (st_q == ST_RD) begin
			rd_w0_q   <= store_w0[idx_q];
			rd_w1_q   <= store_w1[idx_q];
			rd_w2_q   <= store_w2[idx_q];
			rd_link_q <= link_mem[idx_q];
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign full_res    = full_q;
	assign slot        = slot_q;
	assign position    = pos_q;
	assign rank        = rank_out_q;
	assign out_word0   = ow0_q;
	assign out_word1   = ow1_q;
	assign out_word2   = ow2_q;
	assign last        = last_q;

	// The fill count never passes the store size.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= obea_pkg::cnt_t'(ENTRIES))
		else $error("fill count beyond store size");

	// The walk never emits more entries than were stored.
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EMIT) |-> (rank_q < cnt_q))
		else $error("bucket walk ran past the stored entries");

	// When a flush ends, the number of entries emitted equals the number stored.
	a_walk_complete: assert property (@(posedge clk) disable iff (!arst_n)
		fill_done |-> (rank_q == cnt_q))
		else $error("bucket walk missed entries");

	// A finished flush leaves the store empty.
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fill_done |=> (used_q == '0) && (head_v_q == '0))
		else $error("flush did not empty the buckets");

endmodule
